// File: src/lpg_pkg.sv
// shared constants, types and helpers for the line pixel generator
package lpg_pkg;

  // canvas side length and coordinate widths
  localparam int CANVAS_DIM = 64;
  localparam int COORD_W    = 6;
  localparam int CANVAS_W   = 7;
  localparam int CFG_IDX_W  = 2;

  // canvas register reset value
  localparam logic [CANVAS_W-1:0] CANVAS_RESET = CANVAS_W'(CANVAS_DIM);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CANVAS_WIDTH  = 2'd0,
    REG_CANVAS_HEIGHT = 2'd1
  } reg_index_t;

  // quotient and remainder of i*span/n for one axis
  typedef struct packed {
    logic [COORD_W-1:0] quo;
    logic [COORD_W-1:0] rem;
  } frac_t;

  // saturate an incoming coordinate to the canvas
  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] top;
    top = COORD_W'(CANVAS_DIM - 1);
    return (v > top) ? top : v;
  endfunction

  // advance i by one: add the span to the remainder, carry at most once into the quotient
  function automatic frac_t frac_step(input frac_t cur, input logic [COORD_W-1:0] span,
                                      input logic [COORD_W-1:0] n);
    logic [COORD_W:0] sum;
    frac_t            res;
    sum = {1'b0, cur.rem} + {1'b0, span};
    if (sum >= {1'b0, n}) begin
      res.rem = COORD_W'(sum - {1'b0, n});
      res.quo = cur.quo + COORD_W'(1);
    end else begin
      res.rem = COORD_W'(sum);
      res.quo = cur.quo;
    end
    return res;
  endfunction

endpackage

// File: src/line_pixel_generator.sv
// line pixel generator: steps a segment point by point with an incremental divider
//
// A segment is taken when start is high and busy is low. The block then finds the
// step count n (the larger of the x and y spans) in its setup state and emits the
// n+1 points back to back, one per cycle, each marked by point_valid for exactly
// one cycle; the receiver cannot stall, so it must take every point as it comes.
// Each point's offset is i*span/n truncated toward zero, kept as a running quotient
// and remainder per axis that is advanced by one add and compare each cycle.
// last_point marks the final point. busy stays high from the accepting edge until
// the edge after the last point. Canvas size writes on the cfg channel are always
// taken and belong in the idle time between segments.
module line_pixel_generator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [lpg_pkg::COORD_W-1:0]     start_x,
  input  logic [lpg_pkg::COORD_W-1:0]     start_y,
  input  logic [lpg_pkg::COORD_W-1:0]     end_x,
  input  logic [lpg_pkg::COORD_W-1:0]     end_y,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lpg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lpg_pkg::CANVAS_W-1:0]    cfg_data,
  output logic                            point_valid,
  output logic [lpg_pkg::COORD_W-1:0]     point_x,
  output logic [lpg_pkg::COORD_W-1:0]     point_y,
  output logic                            inside_res,
  output logic                            last_point
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [lpg_pkg::CANVAS_W-1:0] canvas_width;
  logic [lpg_pkg::CANVAS_W-1:0] canvas_height;

  // segment registers
  logic [lpg_pkg::COORD_W-1:0] x0;
  logic [lpg_pkg::COORD_W-1:0] y0;
  logic [lpg_pkg::COORD_W-1:0] x1;
  logic [lpg_pkg::COORD_W-1:0] y1;
  logic [lpg_pkg::COORD_W-1:0] adx;
  logic [lpg_pkg::COORD_W-1:0] ady;
  logic                        neg_x;
  logic                        neg_y;
  logic [lpg_pkg::COORD_W-1:0] steps;
  logic [lpg_pkg::COORD_W-1:0] idx;
  lpg_pkg::frac_t              fx;
  lpg_pkg::frac_t              fy;

  logic                        accept;
  logic [lpg_pkg::COORD_W-1:0] adx_next;
  logic [lpg_pkg::COORD_W-1:0] ady_next;
  logic                        at_last;
  lpg_pkg::frac_t              fx_next;
  lpg_pkg::frac_t              fy_next;

  assign accept    = start && (state == ST_IDLE);
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign at_last   = (idx == steps);

  // configuration transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= lpg_pkg::CANVAS_RESET;
      canvas_height <= lpg_pkg::CANVAS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lpg_pkg::REG_CANVAS_WIDTH:  canvas_width  <= cfg_data;
        lpg_pkg::REG_CANVAS_HEIGHT: canvas_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_SETUP;
      ST_SETUP: state_next = ST_EMIT;
      ST_EMIT:  if (at_last) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // spans and step count
  assign adx_next = (x1 >= x0) ? (x1 - x0) : (x0 - x1);
  assign ady_next = (y1 >= y0) ? (y1 - y0) : (y0 - y1);

  // per-point quotient update, one per axis
  assign fx_next = lpg_pkg::frac_step(fx, adx, steps);
  assign fy_next = lpg_pkg::frac_step(fy, ady, steps);

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      x0 <= lpg_pkg::clamp_coord(start_x);
      y0 <= lpg_pkg::clamp_coord(start_y);
      x1 <= lpg_pkg::clamp_coord(end_x);
      y1 <= lpg_pkg::clamp_coord(end_y);
    end
    if (state == ST_SETUP) begin
      adx   <= adx_next;
      ady   <= ady_next;
      neg_x <= (x1 < x0);
      neg_y <= (y1 < y0);
      steps <= (adx_next > ady_next) ? adx_next : ady_next;
      idx   <= '0;
      fx    <= '0;
      fy    <= '0;
    end else if (state == ST_EMIT && !at_last) begin
      idx <= idx + lpg_pkg::COORD_W'(1);
      fx  <= fx_next;
      fy  <= fy_next;
    end
  end

  // point outputs
  assign point_valid = (state == ST_EMIT);
  assign point_x     = neg_x ? (x0 - fx.quo) : (x0 + fx.quo);
  assign point_y     = neg_y ? (y0 - fy.quo) : (y0 + fy.quo);
  assign inside_res  = ({1'b0, point_x} < canvas_width) && ({1'b0, point_y} < canvas_height);
  assign last_point  = at_last;

  // checks
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    point_valid |-> busy)
    else $error("point strobe outside a segment");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    point_valid && last_point |=> !busy)
    else $error("block still busy after last point");

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    point_valid && !last_point |=> point_valid)
    else $error("gap inside a segment's point run");

  a_setup_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !point_valid)
    else $error("point emitted in setup cycle");

endmodule

// File: verif/tb.sv
// self-checking testbench for the line pixel generator: segments in, points checked
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX  = 10;
  localparam int NUM_PHASES  = 10;
  localparam int PHASE_SEGS  = 24;

  // register indexes the block does not implement
  localparam logic [lpg_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [lpg_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct {
    logic [lpg_pkg::COORD_W-1:0] sx;
    logic [lpg_pkg::COORD_W-1:0] sy;
    logic [lpg_pkg::COORD_W-1:0] ex;
    logic [lpg_pkg::COORD_W-1:0] ey;
    int unsigned                 gap;
  } segment_t;

  typedef struct {
    logic [lpg_pkg::COORD_W-1:0] x;
    logic [lpg_pkg::COORD_W-1:0] y;
    logic                        in_canvas;
    logic                        last;
  } point_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic [lpg_pkg::COORD_W-1:0]   start_x = '0;
  logic [lpg_pkg::COORD_W-1:0]   start_y = '0;
  logic [lpg_pkg::COORD_W-1:0]   end_x = '0;
  logic [lpg_pkg::COORD_W-1:0]   end_y = '0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [lpg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lpg_pkg::CANVAS_W-1:0]  cfg_data = '0;
  logic                          point_valid;
  logic [lpg_pkg::COORD_W-1:0]   point_x;
  logic [lpg_pkg::COORD_W-1:0]   point_y;
  logic                          inside_res;
  logic                          last_point;

  // canvas size as the block should hold it
  logic [lpg_pkg::CANVAS_W-1:0]  canvas_w = lpg_pkg::CANVAS_RESET;
  logic [lpg_pkg::CANVAS_W-1:0]  canvas_h = lpg_pkg::CANVAS_RESET;

  segment_t segment_q[$];
  point_t   expected_points[$];
  segment_t held_seg;
  segment_t next_seg;
  bit       next_ready = 1'b0;
  int       segs_queued = 0;
  int       segs_taken = 0;
  int       mismatch_cnt = 0;
  int       cycle_cnt = 0;

  line_pixel_generator u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .point_valid (point_valid),
    .point_x     (point_x),
    .point_y     (point_y),
    .inside_res  (inside_res),
    .last_point  (last_point)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // saturate a coordinate to the canvas side
  function automatic int sat_coord(input logic [lpg_pkg::COORD_W-1:0] v);
    return (int'(v) > lpg_pkg::CANVAS_DIM - 1) ? lpg_pkg::CANVAS_DIM - 1 : int'(v);
  endfunction

  // expand one segment into its points: start + i*delta/n, truncated toward zero
  function automatic void rasterize_segment(input segment_t s);
    int     x0, y0, dx, dy, adx, ady, n, px, py;
    point_t p;
    x0  = sat_coord(s.sx);
    y0  = sat_coord(s.sy);
    dx  = sat_coord(s.ex) - x0;
    dy  = sat_coord(s.ey) - y0;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    n   = (adx > ady) ? adx : ady;
    for (int i = 0; i <= n; i++) begin
      px = (n == 0) ? x0 : x0 + (i * dx) / n;
      py = (n == 0) ? y0 : y0 + (i * dy) / n;
      p.x         = lpg_pkg::COORD_W'(px);
      p.y         = lpg_pkg::COORD_W'(py);
      p.in_canvas = (px < int'(canvas_w)) && (py < int'(canvas_h));
      p.last      = (i == n);
      expected_points.push_back(p);
    end
  endfunction

  task automatic queue_segment(input int sx, input int sy, input int ex, input int ey,
                               input int unsigned gap);
    segment_t s;
    s.sx  = lpg_pkg::COORD_W'(sx);
    s.sy  = lpg_pkg::COORD_W'(sy);
    s.ex  = lpg_pkg::COORD_W'(ex);
    s.ey  = lpg_pkg::COORD_W'(ey);
    s.gap = gap;
    segment_q.push_back(s);
    segs_queued++;
  endtask

  // mostly short and axis-aligned or diagonal segments, the rest fully random
  task automatic queue_random_segments(input int count, input bit back_to_back);
    int x0, y0, x1, y1, d;
    for (int k = 0; k < count; k++) begin
      x0 = $urandom_range(lpg_pkg::CANVAS_DIM - 1, 0);
      y0 = $urandom_range(lpg_pkg::CANVAS_DIM - 1, 0);
      x1 = $urandom_range(lpg_pkg::CANVAS_DIM - 1, 0);
      y1 = $urandom_range(lpg_pkg::CANVAS_DIM - 1, 0);
      case ($urandom_range(9, 0))
        0: begin
          x1 = x0;
          y1 = y0;
        end
        1: y1 = y0;
        2: x1 = x0;
        3: begin
          d  = $urandom_range(lpg_pkg::CANVAS_DIM - 1, 0);
          x0 = $urandom_range(lpg_pkg::CANVAS_DIM - 1 - d, 0);
          y0 = $urandom_range(lpg_pkg::CANVAS_DIM - 1 - d, 0);
          x1 = x0 + d;
          y1 = y0 + d;
          if ($urandom_range(1, 0) == 1) begin
            d  = x0;
            x0 = x1;
            x1 = d;
          end
          if ($urandom_range(1, 0) == 1) begin
            d  = y0;
            y0 = y1;
            y1 = d;
          end
        end
        4, 5, 6: begin
          x1 = x0 + int'($urandom_range(14, 0)) - 7;
          y1 = y0 + int'($urandom_range(14, 0)) - 7;
          if (x1 < 0) x1 = 0;
          if (x1 > lpg_pkg::CANVAS_DIM - 1) x1 = lpg_pkg::CANVAS_DIM - 1;
          if (y1 < 0) y1 = 0;
          if (y1 > lpg_pkg::CANVAS_DIM - 1) y1 = lpg_pkg::CANVAS_DIM - 1;
        end
        default: ;
      endcase
      queue_segment(x0, y0, x1, y1, back_to_back ? 0 : $urandom_range(9, 0));
    end
  endtask

  // one register transfer on the cfg channel, then update the local copy
  task automatic write_canvas_reg(input logic [lpg_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [lpg_pkg::CANVAS_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      lpg_pkg::REG_CANVAS_WIDTH:  canvas_w = val;
      lpg_pkg::REG_CANVAS_HEIGHT: canvas_h = val;
      default: ;
    endcase
  endtask

  // all segments taken, all points seen and the block back to idle
  task automatic wait_idle();
    do @(posedge clk);
    while (segs_taken != segs_queued || expected_points.size() != 0 || busy);
  endtask

  // segment driver: holds start until the transfer, then waits out the next gap
  always @(posedge clk) begin : drive_segments
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        rasterize_segment(held_seg);
        segs_taken++;
      end
      if (!(start && busy)) begin
        if (!next_ready && segment_q.size() != 0) begin
          next_seg   = segment_q.pop_front();
          next_ready = 1'b1;
        end
        if (next_ready && next_seg.gap == 0) begin
          held_seg   = next_seg;
          next_ready = 1'b0;
          start   <= 1'b1;
          start_x <= held_seg.sx;
          start_y <= held_seg.sy;
          end_x   <= held_seg.ex;
          end_y   <= held_seg.ey;
        end else begin
          start <= 1'b0;
          if (next_ready) next_seg.gap--;
        end
      end
    end
  end

  // point monitor: every strobed point is checked against the oldest expected one
  always @(posedge clk) begin : check_points
    point_t want;
    if (!rst && point_valid) begin
      if (expected_points.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("unexpected point: x=%0d y=%0d inside=%0b last=%0b",
                   point_x, point_y, inside_res, last_point);
      end else begin
        want = expected_points.pop_front();
        if (point_x !== want.x || point_y !== want.y ||
            inside_res !== want.in_canvas || last_point !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX) begin
            $display("point mismatch: expected x=%0d y=%0d inside=%0b last=%0b",
                     want.x, want.y, want.in_canvas, want.last);
            $display("                got      x=%0d y=%0d inside=%0b last=%0b",
                     point_x, point_y, inside_res, last_point);
          end
        end
      end
    end
  end

  // watchdog
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [lpg_pkg::CANVAS_W-1:0] w, h;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // writes to unused indexes must leave the canvas alone
    write_canvas_reg(REG_SPARE_2, 7'h7f);
    write_canvas_reg(REG_SPARE_3, 7'h00);

    // directed segments: corners, full diagonals, axis lines, single steps, degenerate
    queue_segment(0, 0, 0, 0, 0);
    queue_segment(63, 63, 63, 63, 0);
    queue_segment(0, 0, 63, 63, 0);
    queue_segment(63, 63, 0, 0, $urandom_range(9, 0));
    queue_segment(0, 63, 63, 0, 0);
    queue_segment(63, 0, 0, 63, $urandom_range(9, 0));
    queue_segment(0, 0, 63, 0, 0);
    queue_segment(63, 5, 0, 5, 0);
    queue_segment(7, 0, 7, 63, $urandom_range(9, 0));
    queue_segment(7, 63, 7, 0, 0);
    queue_segment(5, 10, 40, 17, 0);
    queue_segment(40, 17, 5, 10, $urandom_range(9, 0));
    queue_segment(10, 5, 17, 40, 0);
    queue_segment(0, 0, 1, 0, 0);
    queue_segment(0, 0, 1, 1, $urandom_range(9, 0));
    queue_segment(0, 0, 63, 1, 0);
    queue_segment(62, 1, 0, 0, 0);
    queue_segment(21, 42, 42, 21, $urandom_range(9, 0));
    queue_segment(33, 33, 33, 33, 0);
    wait_idle();

    // random phases, each under its own canvas size
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin w = 7'd1;   h = 7'd1;   end
        1: begin w = 7'd0;   h = 7'd127; end
        2: begin w = 7'd127; h = 7'd0;   end
        3: begin w = 7'd63;  h = 7'd64;  end
        4: begin w = 7'd64;  h = 7'd63;  end
        5: begin w = 7'd65;  h = 7'd1;   end
        6: begin w = 7'd32;  h = 7'd17;  end
        9: begin w = lpg_pkg::CANVAS_RESET; h = lpg_pkg::CANVAS_RESET; end
        default: begin
          w = lpg_pkg::CANVAS_W'($urandom_range(127, 0));
          h = lpg_pkg::CANVAS_W'($urandom_range(127, 0));
        end
      endcase
      write_canvas_reg(lpg_pkg::REG_CANVAS_WIDTH, w);
      write_canvas_reg(lpg_pkg::REG_CANVAS_HEIGHT, h);
      if (ph % 4 == 2) begin
        write_canvas_reg(REG_SPARE_2, lpg_pkg::CANVAS_W'($urandom_range(127, 0)));
        write_canvas_reg(REG_SPARE_3, lpg_pkg::CANVAS_W'($urandom_range(127, 0)));
      end
      queue_random_segments(PHASE_SEGS, ph % 3 == 1);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && expected_points.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
